### hdl/ssu_pkg.sv
// Shared types and codes of the sorted set engine.
`default_nettype none
package ssu_pkg;

	// Width of entries, counts and positions.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 6;

	// Command codes.
	typedef enum logic [2:0] {
		CMD_INSERT    = 3'd0,
		CMD_UNION     = 3'd1,
		CMD_INTERSECT = 3'd2,
		CMD_DIFF      = 3'd3,
		CMD_MEMBER    = 3'd4
	} cmd_e_t;

	// Insert status codes.
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// What a cell does this cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_mode_t;

	// Input item.
	typedef struct packed {
		logic [2:0]        cmd;
		logic              set_select;
		logic [DATA_W-1:0] value;
	} request_t;

	// Result item.
	typedef struct packed {
		logic [DATA_W-1:0] result_value;
		logic              result_valid;
		logic              last;
		logic              found;
		logic [CNT_W-1:0]  position;
		logic [1:0]        status;
	} response_t;

	// Control from the sequencer to one row.
	typedef struct packed {
		cell_mode_t        mode;
		logic [DATA_W-1:0] value;
	} row_ctrl_t;

	// Status from one row to the sequencer.
	typedef struct packed {
		logic [DATA_W-1:0] head;
		logic [CNT_W-1:0]  count;
		logic              full;
		logic              hit;
		logic [CNT_W-1:0]  position;
	} row_stat_t;

endpackage
`default_nettype wire

### hdl/ssu_if.sv
// Valid/ready channel carrying one item of type T.
`default_nettype none
interface ssu_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ssu_cell.sv
// One cell of a set row: holds one entry, compares it, shifts or rotates.
`default_nettype none
module ssu_cell (
	input  wire                        clk,
	input  ssu_pkg::cell_mode_t        mode,
	input  wire [ssu_pkg::DATA_W-1:0]  value,
	input  wire                        valid,
	input  wire [ssu_pkg::DATA_W-1:0]  left_entry,
	input  wire                        left_lt,
	input  wire [ssu_pkg::DATA_W-1:0]  right_entry,
	output logic [ssu_pkg::DATA_W-1:0] entry,
	output logic                       lt,
	output logic                       eq
);
	import ssu_pkg::*;

	logic [DATA_W-1:0] entry_q;

	assign entry = entry_q;
	// Signed compare against the probe value
	assign lt = valid && ($signed(entry_q) < $signed(value));
	assign eq = valid && (entry_q == value);

	// Insert: cells above the slot take the left neighbour, the slot takes value
	always_ff @(posedge clk) begin
		case (mode)
			CELL_INSERT: begin
				if (!lt) begin
					entry_q <= left_lt ? value : left_entry;
				end
			end
			CELL_ROTATE: entry_q <= right_entry;
			default:     entry_q <= entry_q;
		endcase
	end

endmodule
`default_nettype wire

### hdl/ssu_row.sv
// Row of cells holding one sorted set, with its fill count.
`default_nettype none
module ssu_row #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  ssu_pkg::row_ctrl_t ctrl,
	output ssu_pkg::row_stat_t stat
);
	import ssu_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] eq_v;
	logic [CNT_W-1:0]  pos_w;

	// Cells; the virtual cell left of the head counts as below the value
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_W-1:0] left_e;
		logic              left_l;
		logic [DATA_W-1:0] right_e;

		if (k == 0) begin : g_head
			assign left_e = ctrl.value;
			assign left_l = 1'b1;
		end else begin : g_body
			assign left_e = entry_w[k-1];
			assign left_l = lt_v[k-1];
		end
		assign right_e = entry_w[(k + 1) % CAPACITY];

		ssu_cell u_cell (
			.clk         (clk),
			.mode        (ctrl.mode),
			.value       (ctrl.value),
			.valid       (count_q > CNT_W'(k)),
			.left_entry  (left_e),
			.left_lt     (left_l),
			.right_entry (right_e),
			.entry       (entry_w[k]),
			.lt          (lt_v[k]),
			.eq          (eq_v[k])
		);
	end

	// 1-based position of the matching cell, at most one matches
	always_comb begin
		pos_w = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (eq_v[k]) begin
				pos_w = pos_w | CNT_W'(k + 1);
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.mode == CELL_INSERT) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign stat.head     = entry_w[0];
	assign stat.count    = count_q;
	assign stat.full     = count_q >= CNT_W'(CAPACITY);
	assign stat.hit      = |eq_v;
	assign stat.position = pos_w;

endmodule
`default_nettype wire

### hdl/sorted_set_engine.sv
// Sorted set engine top level: command sequencer, two set rows, output register.
// Holds two duplicate-free ascending sets A and B of up to CAPACITY signed 32-bit
// values, each in a row of cells. For insert and membership every cell
// compares its entry with the value at once and an insert shifts the upper part
// of the row one cell up; the answer is registered at the accept edge, so the next
// command can follow in the next cycle if the output is read. Union, intersection
// and difference walk both sets by rotating each row towards its head, one entry
// per cycle unless a step waits on a busy output, then keep rotating until each
// row has turned a full CAPACITY steps and is back in order, and only then hand
// out the final item. One command is worked at a time, and a new one is taken
// only while the output register is empty or being read in that cycle.
// An empty set result gives one item with result_valid low.
`default_nettype none
module sorted_set_engine #(
	parameter int unsigned CAPACITY = 16
) (
	input wire        clk,
	input wire        arst_n,
	ssu_chan_if.sink   request,
	ssu_chan_if.source response
);
	import ssu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REWIND,
		S_FLUSH
	} state_t;

	state_t            state_q;
	cmd_e_t            op_q;
	logic [CNT_W-1:0]  ia_q;
	logic [CNT_W-1:0]  ib_q;
	logic [DATA_W-1:0] hold_q;
	logic              hold_valid_q;
	response_t         out_q;
	logic              out_valid_q;

	row_ctrl_t a_ctrl, b_ctrl;
	row_stat_t a_stat, b_stat, sel_stat;

	logic              slot_free;
	logic              accept;
	logic              a_has, b_has, a_lt, b_lt, ab_eq;
	logic              done, emit, adv_a, adv_b, step_go;
	logic [DATA_W-1:0] emit_val;
	logic              push;
	response_t         push_item;
	logic              ins_go;

	localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);

	// Handshakes
	assign slot_free     = !out_valid_q || response.ready;
	assign request.ready = (state_q == S_IDLE) && slot_free;
	assign accept        = request.valid && request.ready;
	assign response.valid = out_valid_q;
	assign response.data  = out_q;

	assign sel_stat = request.data.set_select ? b_stat : a_stat;
	assign ins_go   = accept && (request.data.cmd == CMD_INSERT)
		&& !sel_stat.hit && !sel_stat.full;

	// Merge step on the two row heads
	assign a_has = ia_q < a_stat.count;
	assign b_has = ib_q < b_stat.count;
	assign a_lt  = $signed(a_stat.head) < $signed(b_stat.head);
	assign b_lt  = $signed(b_stat.head) < $signed(a_stat.head);
	assign ab_eq = a_stat.head == b_stat.head;

	always_comb begin
		done     = 1'b1;
		emit     = 1'b0;
		emit_val = a_stat.head;
		adv_a    = 1'b0;
		adv_b    = 1'b0;
		case (op_q)
			CMD_UNION: begin
				done = !a_has && !b_has;
				emit = 1'b1;
				if (!b_has || (a_has && a_lt)) begin
					adv_a = 1'b1;
				end else if (!a_has || b_lt) begin
					adv_b    = 1'b1;
					emit_val = b_stat.head;
				end else begin
					adv_a = 1'b1;
					adv_b = 1'b1;
				end
			end
			CMD_INTERSECT: begin
				done = !a_has || !b_has;
				if (ab_eq) begin
					emit  = 1'b1;
					adv_a = 1'b1;
					adv_b = 1'b1;
				end else if (a_lt) begin
					adv_a = 1'b1;
				end else begin
					adv_b = 1'b1;
				end
			end
			CMD_DIFF: begin
				done = !a_has;
				if (b_has && b_lt) begin
					adv_b = 1'b1;
				end else if (b_has && ab_eq) begin
					adv_a = 1'b1;
					adv_b = 1'b1;
				end else begin
					emit  = 1'b1;
					adv_a = 1'b1;
				end
			end
			default: done = 1'b1;
		endcase
	end

	// A step stalls only when it must pass the held item to a busy output
	assign step_go = (state_q == S_SCAN) && !done && !(emit && hold_valid_q && !slot_free);

	// Row control
	always_comb begin
		a_ctrl.value = request.data.value;
		b_ctrl.value = request.data.value;
		a_ctrl.mode  = CELL_HOLD;
		b_ctrl.mode  = CELL_HOLD;
		case (state_q)
			S_IDLE: begin
				if (ins_go) begin
					if (request.data.set_select) begin
						b_ctrl.mode = CELL_INSERT;
					end else begin
						a_ctrl.mode = CELL_INSERT;
					end
				end
			end
			S_SCAN: begin
				if (step_go && adv_a) begin
					a_ctrl.mode = CELL_ROTATE;
				end
				if (step_go && adv_b) begin
					b_ctrl.mode = CELL_ROTATE;
				end
			end
			S_REWIND: begin
				if (ia_q != CAP_N) begin
					a_ctrl.mode = CELL_ROTATE;
				end
				if (ib_q != CAP_N) begin
					b_ctrl.mode = CELL_ROTATE;
				end
			end
			default: begin
				a_ctrl.mode = CELL_HOLD;
				b_ctrl.mode = CELL_HOLD;
			end
		endcase
	end

	// Item going into the output register
	always_comb begin
		push      = 1'b0;
		push_item = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					push_item.last = 1'b1;
					case (request.data.cmd)
						CMD_INSERT: begin
							push = 1'b1;
							if (sel_stat.hit) begin
								push_item.status = ST_DUP;
							end else if (sel_stat.full) begin
								push_item.status = ST_FULL;
							end else begin
								push_item.status = ST_DONE;
							end
						end
						CMD_MEMBER: begin
							push               = 1'b1;
							push_item.found    = sel_stat.hit;
							push_item.position = sel_stat.position;
						end
						CMD_UNION, CMD_INTERSECT, CMD_DIFF: push = 1'b0;
						default: push = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (step_go && emit && hold_valid_q) begin
					push                   = 1'b1;
					push_item.result_value = hold_q;
					push_item.result_valid = 1'b1;
				end
			end
			S_FLUSH: begin
				if (slot_free) begin
					push                   = 1'b1;
					push_item.result_value = hold_valid_q ? hold_q : '0;
					push_item.result_valid = hold_valid_q;
					push_item.last         = 1'b1;
				end
			end
			default: push = 1'b0;
		endcase
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= CMD_UNION;
			ia_q         <= '0;
			ib_q         <= '0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_q       <= push_item;
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (request.data.cmd == CMD_UNION
						|| request.data.cmd == CMD_INTERSECT
						|| request.data.cmd == CMD_DIFF)) begin
						op_q         <= cmd_e_t'(request.data.cmd);
						ia_q         <= '0;
						ib_q         <= '0;
						hold_valid_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (done) begin
						state_q <= S_REWIND;
					end else if (step_go) begin
						if (adv_a) begin
							ia_q <= ia_q + 1'b1;
						end
						if (adv_b) begin
							ib_q <= ib_q + 1'b1;
						end
						if (emit) begin
							hold_q       <= emit_val;
							hold_valid_q <= 1'b1;
						end
					end
				end
				S_REWIND: begin
					if (ia_q != CAP_N) begin
						ia_q <= ia_q + 1'b1;
					end
					if (ib_q != CAP_N) begin
						ib_q <= ib_q + 1'b1;
					end
					if (ia_q == CAP_N && ib_q == CAP_N) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ssu_row #(.CAPACITY(CAPACITY)) u_row_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (a_ctrl),
		.stat   (a_stat)
	);

	ssu_row #(.CAPACITY(CAPACITY)) u_row_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (b_ctrl),
		.stat   (b_stat)
	);

	// During the scan, walk pointers never pass the fill counts
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (ia_q <= a_stat.count && ib_q <= b_stat.count))
		else $error("scan pointer beyond set");

	// Both rows are back in order before the final item goes out
	a_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |-> (ia_q == CAP_N && ib_q == CAP_N))
		else $error("row not fully rotated at flush");

	// The fill counts stay within capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		a_stat.count <= CAP_N && b_stat.count <= CAP_N)
		else $error("set count beyond capacity");

	// Only the final item of a command may lack an element
	a_nonlast_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> out_q.result_valid)
		else $error("non-final item without element");

	// The final item ends the command
	a_flush_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH && slot_free |=> state_q == S_IDLE && out_valid_q && out_q.last)
		else $error("flush did not complete command");

endmodule
`default_nettype wire
